### design/button_debounce_hold_classifier_defines.svh
// Assertion macros used by the checker file.
`ifndef BUTTON_DEBOUNCE_HOLD_CLASSIFIER_DEFINES_SVH
`define BUTTON_DEBOUNCE_HOLD_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define BDHC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while in reset.
`define BDHC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/bdhc_pkg.sv
`default_nettype none

package bdhc_pkg;

  localparam int unsigned NUM_CH    = 8;
  localparam int unsigned CH_W      = $clog2(NUM_CH);
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned MASK_W    = 8;

  localparam logic [CFG_W-1:0]  DEBOUNCE_RST = CFG_W'(20);
  localparam logic [CFG_W-1:0]  HOLD_RST     = CFG_W'(300);
  localparam logic [MASK_W-1:0] MASK_RST     = MASK_W'(15);

  typedef enum logic [1:0] {
    KIND_PRESS   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_AUTO    = 2'd2
  } event_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE  = 2'd0,
    REG_HOLD      = 2'd1,
    REG_HOLD_MASK = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [CH_W-1:0]   channel;
    logic              raw_level;
    logic [TIME_W-1:0] current_time;
  } in_word_t;

  typedef struct packed {
    logic [CH_W-1:0]   event_channel;
    logic [1:0]        event_kind;
    logic [TIME_W-1:0] event_time;
  } out_word_t;

  typedef struct packed {
    logic              prev_raw;
    logic              stable_level;
    logic [TIME_W-1:0] change_time;
    logic [TIME_W-1:0] press_start_time;
    logic              hold_reported;
  } chan_state_t;

  typedef struct packed {
    logic            en;
    logic [CH_W-1:0] addr;
    chan_state_t     data;
  } state_wr_t;

endpackage

`default_nettype wire

### design/bdhc_state_mem.sv
`default_nettype none

module bdhc_state_mem (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    rd_en_i,
  input  logic [bdhc_pkg::CH_W-1:0] rd_addr_i,
  input  bdhc_pkg::state_wr_t     wr_i,
  output bdhc_pkg::chan_state_t   rd_data_o
);
  import bdhc_pkg::*;

  chan_state_t       mem [NUM_CH];
  logic [NUM_CH-1:0] valid_q;
  chan_state_t       rd_data_q;

  // entry valid bits: an unwritten channel reads as all-zero state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.addr] <= 1'b1;
    end
  end

  // write, and read with bypass of a same-cycle write to the same entry
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      if (wr_i.en && (wr_i.addr == rd_addr_i)) begin
        rd_data_q <= wr_i.data;
      end else if (valid_q[rd_addr_i]) begin
        rd_data_q <= mem[rd_addr_i];
      end else begin
        rd_data_q <= '0;
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

### design/button_debounce_hold_classifier.sv
`default_nettype none

// Eight-channel button debouncer with long-press classification. Each input
// word carries a channel, its raw level and a wrapping 32-bit timestamp; a
// level is taken as stable once the raw input has held for debounce_ticks.
// Plain channels give a press event on a stable rising edge. Channels whose
// hold_mode_mask bit is set give a press event once held for hold_ticks, and
// on release a release event (press was sent or press was long) or a
// one-touch auto event (short press). At most one result word per input.
// Throughput is one input word per clock, sustained, with any mix of
// channels, while the output is not stalled. The per-channel state memory
// is read at the input accept edge, and the compute stage then writes the
// state back and loads the output register. A write to a channel bypasses
// into a read of the same channel in the same cycle.
// Valid bits clear the state memory at reset, so there is no clearing pass.
// Write configuration registers only while the block is idle.
module button_debounce_hold_classifier (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bdhc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bdhc_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  bdhc_pkg::in_word_t           in_word_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output bdhc_pkg::out_word_t          out_word_o
);
  import bdhc_pkg::*;

  // Configuration registers
  logic [CFG_W-1:0]  debounce_q;
  logic [CFG_W-1:0]  hold_q;
  logic [MASK_W-1:0] hold_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q  <= DEBOUNCE_RST;
      hold_q      <= HOLD_RST;
      hold_mask_q <= MASK_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DEBOUNCE:  debounce_q  <= cfg_wdata_i;
        REG_HOLD:      hold_q      <= cfg_wdata_i;
        REG_HOLD_MASK: hold_mask_q <= cfg_wdata_i[MASK_W-1:0];
        default:       ;
      endcase
    end
  end

  // Pipeline control
  logic        s1_q;
  in_word_t    s1_word_q;
  logic        out_valid_q;
  out_word_t   out_word_q;
  logic        in_acc;
  logic        s1_go;

  // compute stage moves on whenever the output register is free or draining
  assign s1_go      = s1_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_q || !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0;
    end else if (in_acc) begin
      s1_q <= 1'b1;
    end else if (s1_go) begin
      s1_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_word_q <= in_word_i;
    end
  end

  // Per-channel state memory
  state_wr_t   wr;
  chan_state_t st;

  bdhc_state_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_addr_i (in_word_i.channel),
    .wr_i      (wr),
    .rd_data_o (st)
  );

  // Compute stage: debounce, then classify
  logic              raw;
  logic [TIME_W-1:0] now;
  logic              hold_mode;
  logic [TIME_W-1:0] chg_time;
  logic [TIME_W-1:0] since_chg;
  logic [TIME_W-1:0] press_dur;
  logic              deb_ok;
  logic              long_press;
  logic              rising;
  chan_state_t       nst;
  logic              ev_valid;
  event_kind_e       ev_kind;

  always_comb begin
    raw        = s1_word_q.raw_level;
    now        = s1_word_q.current_time;
    hold_mode  = hold_mask_q[s1_word_q.channel];
    chg_time   = (raw != st.prev_raw) ? now : st.change_time;
    since_chg  = now - chg_time;
    deb_ok     = since_chg >= TIME_W'(debounce_q);
    press_dur  = now - st.press_start_time;
    long_press = press_dur >= TIME_W'(hold_q);
    rising     = deb_ok && raw && !st.stable_level;

    nst             = st;
    nst.prev_raw    = raw;
    nst.change_time = chg_time;
    ev_valid        = 1'b0;
    ev_kind         = KIND_PRESS;

    if (deb_ok && (raw != st.stable_level)) begin
      nst.stable_level = raw;
      if (raw) begin
        // new stable press: restart the hold timer
        nst.press_start_time = now;
        nst.hold_reported    = 1'b0;
        if (!hold_mode) begin
          ev_valid = 1'b1;
          ev_kind  = KIND_PRESS;
        end
      end else if (hold_mode) begin
        ev_valid = 1'b1;
        ev_kind  = (st.hold_reported || long_press) ? KIND_RELEASE : KIND_AUTO;
      end
    end

    // hold check; on the rising sample the held time is zero
    if (deb_ok && hold_mode && nst.stable_level && !nst.hold_reported) begin
      if (rising ? (hold_q == '0) : long_press) begin
        nst.hold_reported = 1'b1;
        ev_valid          = 1'b1;
        ev_kind           = KIND_PRESS;
      end
    end

    wr.en   = s1_go;
    wr.addr = s1_word_q.channel;
    wr.data = nst;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go) begin
      out_valid_q <= ev_valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && ev_valid) begin
      out_word_q.event_channel <= s1_word_q.channel;
      out_word_q.event_kind    <= ev_kind;
      out_word_q.event_time    <= now;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire

### design/bdhc_checker.sv
`default_nettype none

`include "button_debounce_hold_classifier_defines.svh"

module bdhc_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bdhc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bdhc_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_o,
  input  bdhc_pkg::in_word_t           in_word_i,
  input  logic                         out_valid_o,
  input  logic                         out_ready_i,
  input  bdhc_pkg::out_word_t          out_word_o
);
  import bdhc_pkg::*;

  logic out_stall;
  logic cfg_seen;

  assign out_stall = out_valid_o && !out_ready_i;
  // keep the config and input ports referenced for the bind
  assign cfg_seen  = cfg_we_i && (cfg_idx_i != '0) && (cfg_wdata_i != '0) && in_valid_i
                     && in_word_i.raw_level;

  `BDHC_ASSERT_NEXT(a_out_hold, out_stall, out_valid_o, "output word dropped while stalled")
  `BDHC_ASSERT_NEXT(a_out_stable, out_stall, $stable(out_word_o), "output word changed while stalled")
  `BDHC_ASSERT_NOW(a_kind_legal, out_valid_o || cfg_seen, !out_valid_o || out_word_o.event_kind == KIND_PRESS || out_word_o.event_kind == KIND_RELEASE || out_word_o.event_kind == KIND_AUTO, "illegal event kind")
  `BDHC_ASSERT_NOW(a_no_bubble, !out_stall, in_ready_o, "input stalled with a free output")

endmodule

bind button_debounce_hold_classifier bdhc_checker u_bdhc_checker (.*);

`default_nettype wire
